// ===== src/nbody_gravity_step_assert.svh =====
// Assertion helpers shared by the RTL files.
`ifndef NBODY_GRAVITY_STEP_ASSERT_SVH
`define NBODY_GRAVITY_STEP_ASSERT_SVH

// Clocked check on clk_i, quiet while rst_ni is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  `ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

// ===== src/ngs_pkg.sv =====
package ngs_pkg;

  localparam int DW     = 48;
  localparam int MW     = 32;
  localparam int W      = 194;  // cube << 47 fits here
  localparam int CUBE_W = 147;
  localparam int GM_W   = 80;
  localparam int ROOT_W = 49;

  localparam logic [DW-1:0] PULL_LIM = {1'b0, {(DW-1){1'b1}}};

  localparam logic CFG_LIVE_COUNT = 1'b0;
  localparam logic CFG_GRAVITY    = 1'b1;

  typedef struct packed {
    logic signed [DW-1:0] pos_x;
    logic signed [DW-1:0] pos_y;
    logic signed [DW-1:0] vel_x;
    logic signed [DW-1:0] vel_y;
    logic [MW-1:0]        mass;
    logic                 fixed;
  } body_t;

  typedef struct packed {
    logic                 start;
    logic signed [DW:0]   dx;
    logic signed [DW:0]   dy;
    logic [DW-1:0]        g;
    logic [MW-1:0]        m2;
  } pair_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [DW-1:0] pull_x;
    logic signed [DW-1:0] pull_y;
  } pair_rsp_t;

  function automatic logic signed [DW-1:0] sat48(input logic signed [DW+5:0] v);
    logic signed [DW+5:0] hi;
    logic signed [DW+5:0] lo;
    hi = (DW+6)'(signed'({1'b0, {(DW-1){1'b1}}}));
    lo = -hi - (DW+6)'(1);
    if (v > hi) return hi[DW-1:0];
    if (v < lo) return lo[DW-1:0];
    return v[DW-1:0];
  endfunction

endpackage

// ===== src/ngs_store.sv =====
module ngs_store
  import ngs_pkg::*;
#(
  parameter int MAX_BODIES = 16
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [$clog2(MAX_BODIES)-1:0] waddr_i,
  input  body_t                         wdata_i,
  input  logic [$clog2(MAX_BODIES)-1:0] raddr_i,
  output body_t                         rdata_o
);

  body_t mem_q [MAX_BODIES];
  body_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ngs_pair.sv =====
`include "nbody_gravity_step_assert.svh"

module ngs_pair
  import ngs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pair_req_t req_i,
  output pair_rsp_t rsp_o
);

  typedef enum logic [10:0] {
    P_IDLE = 11'd1,
    P_SQX  = 11'd2,
    P_SQY  = 11'd4,
    P_ROOT = 11'd8,
    P_CUB1 = 11'd16,
    P_CUB2 = 11'd32,
    P_GM   = 11'd64,
    P_NX   = 11'd128,
    P_DX   = 11'd256,
    P_NY   = 11'd512,
    P_DY   = 11'd1024
  } pstate_e;

  pstate_e state_q, state_d;
  logic    done_q, done_d;

  logic [W-1:0]      acc_q, acc_d, mcand_q, mcand_d;
  logic [ROOT_W-1:0] mpl_q, mpl_d, root_q, root_d;
  logic [96:0]       one_q, one_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [CUBE_W-1:0] cube_q, cube_d;
  logic [GM_W-1:0]   gm_q, gm_d;
  logic [DW-1:0]     mx_q, mx_d, my_q, my_d, g_q, g_d;
  logic [MW-1:0]     m2_q, m2_d;
  logic              sx_q, sx_d, sy_q, sy_d;
  logic [DW-2:0]     q_q, q_d;
  logic signed [DW-1:0] px_q, px_d, py_q, py_d;

  // shared add/subtract unit
  logic [W-1:0] opb;
  logic         sub;
  logic [W:0]   sum_w;
  logic         no_borrow;

  logic [W-1:0]  res_nx;
  logic [DW-2:0] q_nx;
  logic [DW-1:0] mag;
  logic signed [DW-1:0] pull;
  logic          is_y;
  logic          sgn;

  always_comb begin
    opb = mcand_q;
    sub = 1'b0;
    if (state_q == P_ROOT) begin
      opb = mcand_q | W'(one_q);
      sub = 1'b1;
    end else if (state_q == P_DX || state_q == P_DY) begin
      sub = 1'b1;
    end
  end

  assign sum_w     = {1'b0, acc_q} + {1'b0, (sub ? ~opb : opb)} + (W+1)'(sub);
  assign no_borrow = sum_w[W];
  assign res_nx    = no_borrow ? ((mcand_q >> 1) | W'(one_q)) : (mcand_q >> 1);
  assign q_nx      = {q_q[DW-3:0], no_borrow};
  assign is_y      = (state_q == P_DY);
  assign sgn       = is_y ? sy_q : sx_q;
  assign mag       = (no_borrow && cnt_q == 6'd0) ? PULL_LIM : {1'b0, q_nx};
  assign pull      = sgn ? -signed'(mag) : signed'(mag);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    mpl_d   = mpl_q;
    root_d  = root_q;
    one_d   = one_q;
    cnt_d   = cnt_q;
    cube_d  = cube_q;
    gm_d    = gm_q;
    mx_d    = mx_q;
    my_d    = my_q;
    g_d     = g_q;
    m2_d    = m2_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    q_d     = q_q;
    px_d    = px_q;
    py_d    = py_q;

    unique case (state_q)
      P_IDLE: begin
        if (req_i.start) begin
          mx_d = req_i.dx[DW] ? DW'(-req_i.dx) : DW'(req_i.dx);
          my_d = req_i.dy[DW] ? DW'(-req_i.dy) : DW'(req_i.dy);
          sx_d = req_i.dx[DW];
          sy_d = req_i.dy[DW];
          g_d  = req_i.g;
          m2_d = req_i.m2;
          px_d = '0;
          py_d = '0;
          // coincident bodies pull nothing
          if (req_i.dx == '0 && req_i.dy == '0) begin
            done_d = 1'b1;
          end else begin
            acc_d   = '0;
            mcand_d = W'(mx_d);
            mpl_d   = ROOT_W'(mx_d);
            state_d = P_SQX;
          end
        end
      end
      P_SQX, P_SQY, P_CUB1, P_CUB2, P_GM, P_NX, P_NY: begin
        if (mpl_q == '0) begin
          unique case (state_q)
            P_SQX: begin
              mcand_d = W'(my_q);
              mpl_d   = ROOT_W'(my_q);
              state_d = P_SQY;
            end
            P_SQY: begin
              mcand_d = '0;
              one_d   = 97'(1) << 96;
              cnt_d   = '0;
              state_d = P_ROOT;
            end
            P_CUB1: begin
              mcand_d = acc_q;
              acc_d   = '0;
              mpl_d   = root_q;
              state_d = P_CUB2;
            end
            P_CUB2: begin
              cube_d  = acc_q[CUBE_W-1:0];
              acc_d   = '0;
              mcand_d = W'(g_q);
              mpl_d   = ROOT_W'(m2_q);
              state_d = P_GM;
            end
            P_GM: begin
              gm_d    = acc_q[GM_W-1:0];
              acc_d   = '0;
              mcand_d = W'(acc_q[GM_W-1:0]);
              mpl_d   = ROOT_W'(mx_q);
              state_d = P_NX;
            end
            default: begin
              // numerator done: scale by 2^32, divisor starts at cube << 47
              acc_d   = acc_q << 32;
              mcand_d = W'(cube_q) << (DW-1);
              cnt_d   = '0;
              q_d     = '0;
              state_d = (state_q == P_NY) ? P_DY : P_DX;
            end
          endcase
        end else begin
          if (mpl_q[0]) acc_d = sum_w[W-1:0];
          mcand_d = mcand_q << 1;
          mpl_d   = mpl_q >> 1;
        end
      end
      P_ROOT: begin
        if (no_borrow) acc_d = sum_w[W-1:0];
        mcand_d = res_nx;
        one_d   = one_q >> 2;
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q == 6'd48) begin
          root_d  = res_nx[ROOT_W-1:0];
          acc_d   = '0;
          mcand_d = W'(res_nx[ROOT_W-1:0]);
          mpl_d   = res_nx[ROOT_W-1:0];
          state_d = P_CUB1;
        end
      end
      P_DX, P_DY: begin
        if (no_borrow) acc_d = sum_w[W-1:0];
        mcand_d = mcand_q >> 1;
        q_d     = q_nx;
        cnt_d   = cnt_q + 6'd1;
        if ((no_borrow && cnt_q == 6'd0) || cnt_q == 6'd47) begin
          if (is_y) begin
            py_d    = pull;
            done_d  = 1'b1;
            state_d = P_IDLE;
          end else begin
            px_d    = pull;
            acc_d   = '0;
            mcand_d = W'(gm_q);
            mpl_d   = ROOT_W'(my_q);
            state_d = P_NY;
          end
        end
      end
      default: state_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    mpl_q   <= mpl_d;
    root_q  <= root_d;
    one_q   <= one_d;
    cnt_q   <= cnt_d;
    cube_q  <= cube_d;
    gm_q    <= gm_d;
    mx_q    <= mx_d;
    my_q    <= my_d;
    g_q     <= g_d;
    m2_q    <= m2_d;
    sx_q    <= sx_d;
    sy_q    <= sy_d;
    q_q     <= q_d;
    px_q    <= px_d;
    py_q    <= py_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.pull_x = px_q;
  assign rsp_o.pull_y = py_q;

  `ASSERT_IMPL(a_done_idle, done_q, state_q == P_IDLE, "pair done outside idle")
  `ASSERT_IMPL(a_root_cnt, state_q == P_ROOT, cnt_q <= 6'd48, "root step overrun")
  `ASSERT_IMPL(a_div_cnt, state_q == P_DX || state_q == P_DY, cnt_q <= 6'd47,
               "divide step overrun")

endmodule

// ===== src/nbody_gravity_step.sv =====
// Tick: the word is taken, then each movable body is read and every other body is
// read and sent to the pair unit, which works in its shared add/subtract unit
// (multiplies end early on small operands, a saturated divide stops at once, a
// coincident pair returns at once); a fixed body is skipped. Emission then shows
// the body words in turn. One word is in work at a time. Reset (async, active low)
// clears control, the live count to 0 and G to 1.0; body storage is undefined.
`include "nbody_gravity_step_assert.svh"

module nbody_gravity_step
  import ngs_pkg::*;
#(
  parameter int MAX_BODIES = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [47:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // body_index, load_pos_x, load_pos_y, load_vel_x, load_vel_y, load_mass, load_fixed
  input  logic [231:0] s_axis_tdata,
  // action
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_index, out_pos_x, out_pos_y, out_vel_x, out_vel_y
  output logic [199:0] m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int AW  = $clog2(MAX_BODIES);
  localparam int CW  = $clog2(MAX_BODIES + 1);
  localparam int LIM = (MAX_BODIES < 16) ? MAX_BODIES : 16;

  typedef enum logic [10:0] {
    T_IDLE = 11'd1,
    T_RDA  = 11'd2,
    T_LATA = 11'd4,
    T_RDB  = 11'd8,
    T_LATB = 11'd16,
    T_PAIR = 11'd32,
    T_VEL  = 11'd64,
    T_POS  = 11'd128,
    T_ERD  = 11'd256,
    T_ELD  = 11'd512,
    T_EOUT = 11'd1024
  } tstate_e;

  tstate_e state_q, state_d;
  logic [CW-1:0] n_q, n_d, a_q, a_d, b_q, b_d;
  logic [4:0]    bc_q;
  logic [47:0]   g_q;
  body_t         cur_q, cur_d;
  logic signed [DW+4:0] ax_q, ax_d, ay_q, ay_d;
  logic          valid_q, valid_d;
  logic [199:0]  odata_q, odata_d;
  logic          olast_q, olast_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  body_t         wdata, rdata, ld_body;
  pair_req_t     req;
  pair_rsp_t     rsp;
  logic          in_acc;
  logic [3:0]    ld_idx;
  logic signed [DW-1:0] vx_new, vy_new, px_new, py_new;
  logic          a_last, b_last;

  ngs_store #(.MAX_BODIES(MAX_BODIES)) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ngs_pair u_pair (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == T_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign ld_idx        = s_axis_tdata[3:0];
  assign ld_body.pos_x = s_axis_tdata[51:4];
  assign ld_body.pos_y = s_axis_tdata[99:52];
  assign ld_body.vel_x = s_axis_tdata[147:100];
  assign ld_body.vel_y = s_axis_tdata[195:148];
  assign ld_body.mass  = s_axis_tdata[227:196];
  assign ld_body.fixed = s_axis_tdata[228];

  assign a_last = (a_q + CW'(1) == n_q);
  assign b_last = (b_q + CW'(1) == n_q);

  assign vx_new = sat48((DW+6)'(cur_q.vel_x) + (DW+6)'(ax_q));
  assign vy_new = sat48((DW+6)'(cur_q.vel_y) + (DW+6)'(ay_q));
  assign px_new = sat48((DW+6)'(cur_q.pos_x) + (DW+6)'(cur_q.vel_x));
  assign py_new = sat48((DW+6)'(cur_q.pos_y) + (DW+6)'(cur_q.vel_y));

  assign raddr = (state_q == T_RDB) ? b_q[AW-1:0] : a_q[AW-1:0];

  always_comb begin
    we    = 1'b0;
    waddr = a_q[AW-1:0];
    wdata = cur_q;
    if (state_q == T_POS) begin
      we          = 1'b1;
      wdata.pos_x = px_new;
      wdata.pos_y = py_new;
    end else if (in_acc && !s_axis_tuser && (32'(ld_idx) < MAX_BODIES)) begin
      we    = 1'b1;
      waddr = AW'(ld_idx);
      wdata = ld_body;
    end
  end

  always_comb begin
    req.start = (state_q == T_LATB) && (b_q != a_q);
    req.dx    = (DW+1)'(rdata.pos_x) - (DW+1)'(cur_q.pos_x);
    req.dy    = (DW+1)'(rdata.pos_y) - (DW+1)'(cur_q.pos_y);
    req.g     = g_q;
    req.m2    = rdata.mass;
  end

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    a_d     = a_q;
    b_d     = b_q;
    cur_d   = cur_q;
    ax_d    = ax_q;
    ay_d    = ay_q;
    valid_d = valid_q;
    odata_d = odata_q;
    olast_d = olast_q;

    unique case (state_q)
      T_IDLE: begin
        if (in_acc && s_axis_tuser) begin
          n_d = (32'(bc_q) > LIM) ? CW'(LIM) : CW'(bc_q);
          a_d = '0;
          if (n_d != '0) state_d = T_RDA;
        end
      end
      T_RDA: state_d = T_LATA;
      T_LATA: begin
        cur_d = rdata;
        ax_d  = '0;
        ay_d  = '0;
        b_d   = '0;
        if (rdata.fixed) begin
          // immovable: skip straight to next body, or to emission after the last
          a_d     = a_last ? '0 : a_q + CW'(1);
          state_d = a_last ? T_ERD : T_RDA;
        end else begin
          state_d = T_RDB;
        end
      end
      T_RDB: state_d = T_LATB;
      T_LATB: begin
        if (b_q == a_q) begin
          b_d     = b_q + CW'(1);
          state_d = b_last ? T_VEL : T_RDB;
        end else begin
          state_d = T_PAIR;
        end
      end
      T_PAIR: begin
        if (rsp.done) begin
          ax_d    = ax_q + (DW+5)'(rsp.pull_x);
          ay_d    = ay_q + (DW+5)'(rsp.pull_y);
          b_d     = b_q + CW'(1);
          state_d = b_last ? T_VEL : T_RDB;
        end
      end
      T_VEL: begin
        cur_d.vel_x = vx_new;
        cur_d.vel_y = vy_new;
        state_d     = T_POS;
      end
      T_POS: begin
        a_d     = a_last ? '0 : a_q + CW'(1);
        state_d = a_last ? T_ERD : T_RDA;
      end
      T_ERD: state_d = T_ELD;
      T_ELD: begin
        odata_d = {4'd0, rdata.vel_y, rdata.vel_x, rdata.pos_y, rdata.pos_x,
                   4'(a_q)};
        olast_d = a_last;
        valid_d = 1'b1;
        state_d = T_EOUT;
      end
      T_EOUT: begin
        if (m_axis_tready) begin
          valid_d = 1'b0;
          a_d     = a_q + CW'(1);
          state_d = a_last ? T_IDLE : T_ERD;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      valid_q <= 1'b0;
      n_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      bc_q    <= '0;
      g_q     <= 48'h0100_0000_0000;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      n_q     <= n_d;
      a_q     <= a_d;
      b_q     <= b_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_LIVE_COUNT: bc_q <= cfg_data_i[4:0];
          CFG_GRAVITY:    g_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    odata_q <= odata_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

  `ASSERT_IMPL(a_out_state, m_axis_tvalid, state_q == T_EOUT, "word shown outside emit")
  `ASSERT_IMPL(a_done_wait, rsp.done, state_q == T_PAIR, "pair done while not waiting")
  `ASSERT_IMPL(a_idx_range, state_q != T_IDLE, a_q < n_q, "body index past count")

endmodule

// ===== tb/sv/tb_nbody_gravity_step.sv =====
`timescale 1ns / 1ps

module tb_nbody_gravity_step;
  import ngs_pkg::*;

  localparam int  NB        = 16;
  localparam int  SETTLE    = 400;
  localparam longint LIMIT  = 20000000;
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TICK = 1'b1;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = -64'sh8000_0000_0000;

  class gravity_board;
    logic signed [47:0] px[NB], py[NB], vx[NB], vy[NB];
    logic [31:0] mass[NB];
    bit fixed[NB];
    logic [4:0] count;
    logic [47:0] g;
    logic [200:0] pending_bodies[$];  // {last, tdata}
    int errors;
    int ticks;
    int results;

    function new();
      count = 0;
      g = 48'h1 << 40;
      errors = 0;
      ticks = 0;
      results = 0;
      for (int i = 0; i < NB; i++) begin
        px[i] = 0; py[i] = 0; vx[i] = 0; vy[i] = 0; mass[i] = 0; fixed[i] = 0;
      end
    endfunction

    function void write_reg(logic idx, logic [47:0] d);
      if (idx == CFG_LIVE_COUNT) count = d[4:0];
      else g = d;
    endfunction

    function logic signed [63:0] clip48(logic signed [63:0] v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
    endfunction

    // signed pull on one axis; truncate toward zero, clip magnitude
    function logic signed [63:0] axis_pull(logic signed [63:0] d, logic [255:0] cube,
                                           logic [31:0] m2);
      logic [255:0] mag;
      logic [255:0] num;
      logic [255:0] q;
      if (d == 0) return 0;
      mag = (d < 0) ? 256'(-d) : 256'(d);
      num = (256'(g) * 256'(m2) * mag) << 32;
      q = num / cube;
      if (q > 256'(PULL_LIM)) q = 256'(PULL_LIM);
      return (d < 0) ? -$signed(64'(q)) : $signed(64'(q));
    endfunction

    function void note_word(logic act, logic [231:0] d);
      int n;
      logic signed [63:0] ax, ay, dx, dy;
      logic [255:0] r2, r, c, cube;
      if (act == ACT_LOAD) begin
        px[d[3:0]] = d[51:4];
        py[d[3:0]] = d[99:52];
        vx[d[3:0]] = d[147:100];
        vy[d[3:0]] = d[195:148];
        mass[d[3:0]] = d[227:196];
        fixed[d[3:0]] = d[228];
        return;
      end
      ticks++;
      n = (count > NB) ? NB : int'(count);
      for (int a = 0; a < n; a++) begin
        if (fixed[a]) continue;
        ax = 0;
        ay = 0;
        for (int b = 0; b < n; b++) begin
          if (a == b) continue;
          dx = $signed(px[b]) - $signed(px[a]);
          dy = $signed(py[b]) - $signed(py[a]);
          if (dx == 0 && dy == 0) continue;
          r2 = 256'(dx < 0 ? -dx : dx) * 256'(dx < 0 ? -dx : dx)
             + 256'(dy < 0 ? -dy : dy) * 256'(dy < 0 ? -dy : dy);
          r = 0;
          for (int bit_i = 49; bit_i >= 0; bit_i--) begin
            c = r | (256'(1) << bit_i);
            if (c * c <= r2) r = c;
          end
          cube = r * r * r;
          ax += axis_pull(dx, cube, mass[b]);
          ay += axis_pull(dy, cube, mass[b]);
        end
        vx[a] = 48'(clip48($signed(vx[a]) + ax));
        vy[a] = 48'(clip48($signed(vy[a]) + ay));
        px[a] = 48'(clip48($signed(px[a]) + $signed(vx[a])));
        py[a] = 48'(clip48($signed(py[a]) + $signed(vy[a])));
      end
      for (int a = 0; a < n; a++)
        pending_bodies.push_back({(a == n - 1), 4'b0, vy[a], vx[a], py[a], px[a], 4'(a)});
    endfunction

    function void check_body(logic [199:0] d, logic last);
      logic [200:0] e;
      results++;
      if (pending_bodies.size() == 0) begin
        $display("%0t: unexpected body word %h last %b", $time, d, last);
        errors++;
        return;
      end
      e = pending_bodies.pop_front();
      if (e[3:0] != d[3:0]) begin
        $display("%0t: index exp %0d got %0d", $time, e[3:0], d[3:0]); errors++;
      end
      if (e[51:4] != d[51:4]) begin
        $display("%0t: pos_x exp %h got %h", $time, e[51:4], d[51:4]); errors++;
      end
      if (e[99:52] != d[99:52]) begin
        $display("%0t: pos_y exp %h got %h", $time, e[99:52], d[99:52]); errors++;
      end
      if (e[147:100] != d[147:100]) begin
        $display("%0t: vel_x exp %h got %h", $time, e[147:100], d[147:100]); errors++;
      end
      if (e[195:148] != d[195:148]) begin
        $display("%0t: vel_y exp %h got %h", $time, e[195:148], d[195:148]); errors++;
      end
      if (e[200] != last) begin
        $display("%0t: last exp %b got %b", $time, e[200], last); errors++;
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic         cfg_index_i = 1'b0;
  logic [47:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [231:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [199:0] m_axis_tdata;
  logic         m_axis_tlast;

  gravity_board board = new();
  int send_idle = 0;
  int recv_idle = 0;
  longint cycles = 0;

  nbody_gravity_step u_dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_nbody_gravity_step: errors");
      $finish;
    end
  end

  // check each body word, then roll the next stall
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_body(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic send_word(logic act, logic [231:0] d);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= act;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_word(act, d);
  endtask

  // hold input low until every body word is out, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_bodies.size() > 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [47:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [231:0] body_word(logic [3:0] idx, logic [47:0] px, logic [47:0] py,
                                             logic [47:0] vx, logic [47:0] vy,
                                             logic [31:0] m, logic f);
    return {3'b0, f, m, vy, vx, py, px, idx};
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()} >> 16);
  endfunction

  // near-scale value: a signed 32-bit random word shifted right, small beside the 48-bit range
  function automatic logic [47:0] near48(int shift);
    logic signed [47:0] v;
    v = $signed($urandom());
    return v >>> shift;
  endfunction

  function automatic logic [231:0] rand_body(logic [3:0] idx);
    if ($urandom_range(99) < 75)
      return body_word(idx, near48(2), near48(2), near48(10), near48(10),
                       $urandom() >> $urandom_range(31, 8), ($urandom_range(9) == 0));
    return body_word(idx, rand48(), rand48(), rand48(), rand48(), $urandom(),
                     1'($urandom()));
  endfunction

  task automatic tick();
    send_word(ACT_TICK, '0);
  endtask

  initial begin
    logic [47:0] ones;
    int n;
    ones = '1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: extremes, coincident pair, fixed body, zero and full mass
    send_word(ACT_LOAD, body_word(4'd0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000,
                                  48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, '1, 1'b0));
    send_word(ACT_LOAD, body_word(4'd1, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF,
                                  48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, '1, 1'b0));
    send_word(ACT_LOAD, body_word(4'd2, 48'h0100_0000, 48'd0, 48'd0, 48'd0, 32'd1000,
                                  1'b0));
    send_word(ACT_LOAD, body_word(4'd3, 48'h0100_0000, 48'd0, 48'd0, 48'd0, 32'd0, 1'b0));
    send_word(ACT_LOAD, body_word(4'd4, 48'd0, 48'h0200_0000, 48'd0, 48'd0, 32'd5000,
                                  1'b1));
    for (int i = 5; i < NB; i++) send_word(ACT_LOAD, rand_body(4'(i)));
    drain();
    write_reg(CFG_LIVE_COUNT, 48'd2);
    tick();
    drain();
    write_reg(CFG_LIVE_COUNT, 48'd0);
    tick();
    drain();
    write_reg(CFG_LIVE_COUNT, 48'd5);
    write_reg(CFG_GRAVITY, 48'd0);
    tick();
    drain();
    write_reg(CFG_GRAVITY, ones);
    tick();
    drain();
    write_reg(CFG_LIVE_COUNT, 48'd31);
    write_reg(CFG_GRAVITY, 48'h1 << 40);
    tick();
    drain();

    // random: idle profiles, each used in two phases with their own register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 53; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 53; end
        default: begin send_idle = 34; recv_idle = 34; end
      endcase
      n = (ph == 6) ? 16 : $urandom_range(6, 2);
      write_reg(CFG_LIVE_COUNT, 48'(n));
      write_reg(CFG_GRAVITY, ($urandom_range(3) == 0) ? rand48()
                : (48'h1 << 40) >> $urandom_range(8));
      for (int k = 0; k < ((ph == 6) ? 3 : 12); k++) begin
        if ($urandom_range(99) < 40) tick();
        else send_word(ACT_LOAD, rand_body(($urandom_range(3) == 0) ? 4'($urandom())
                                           : 4'($urandom_range(n - 1))));
      end
      tick();
      drain();
    end

    $display("covered %0d ticks, %0d body words checked, counts 0 to 31, G from 0 to max",
             board.ticks, board.results);
    $display("idle profiles: none, sender, receiver, both; full drain between settings");
    if (board.errors == 0 && board.pending_bodies.size() == 0) begin
      $display("tb_nbody_gravity_step: clean");
    end else begin
      $display("tb_nbody_gravity_step: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ngs_pkg.sv
src/ngs_store.sv
src/ngs_pair.sv
src/nbody_gravity_step.sv
tb/sv/tb_nbody_gravity_step.sv
